// ===== sv/salc_pkg.sv =====
`default_nettype none
package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_FETCH  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic             was_hit;
    logic             was_miss;
    logic             was_eviction;
    logic             modify_extra_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } out_item_t;

endpackage
`default_nettype wire

// ===== sv/salc_ram.sv =====
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/salc_way_sel.sv =====
`default_nettype none
module salc_way_sel #(
  parameter int MAX_WAYS = 8
) (
  input  wire logic [MAX_WAYS*(1+salc_pkg::TAG_W+salc_pkg::STAMP_W)-1:0] row,
  input  wire logic [salc_pkg::TAG_W-1:0]                              tag,
  input  wire logic [MAX_WAYS-1:0]                                     in_use,
  output logic                                                         hit,
  output logic                                                         evict,
  output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0]             sel_way
);
  import salc_pkg::*;

  localparam int IDX_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LEAVES     = 1 << $clog2(MAX_WAYS);
  localparam int NODES      = 2 * LEAVES - 1;
  localparam int TAG_BASE   = MAX_WAYS;
  localparam int STAMP_BASE = MAX_WAYS + MAX_WAYS * TAG_W;

  logic [STAMP_W-1:0] nd_stamp [NODES];
  logic [IDX_W-1:0]   nd_idx   [NODES];
  logic               nd_ok    [NODES];
  logic [IDX_W-1:0]   hit_way;
  logic [IDX_W-1:0]   free_way;
  logic               full;

  // lowest matching way wins, highest free way is filled
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    full     = 1'b1;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && row[w] && row[TAG_BASE + TAG_W*w +: TAG_W] == tag) begin
        hit     = 1'b1;
        hit_way = IDX_W'(w);
      end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && !row[w]) begin
        full     = 1'b0;
        free_way = IDX_W'(w);
      end
    end
  end

  // min-stamp tournament, left child holds the lower ways so ties go low
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < MAX_WAYS) begin
        nd_stamp[LEAVES-1+i] = row[STAMP_BASE + STAMP_W*i +: STAMP_W];
        nd_ok[LEAVES-1+i]    = in_use[i];
      end else begin
        nd_stamp[LEAVES-1+i] = '0;
        nd_ok[LEAVES-1+i]    = 1'b0;
      end
      nd_idx[LEAVES-1+i] = IDX_W'(i);
    end
    for (int n = LEAVES - 2; n >= 0; n--) begin
      if (nd_ok[2*n+1] && (!nd_ok[2*n+2] || nd_stamp[2*n+2] >= nd_stamp[2*n+1])) begin
        nd_stamp[n] = nd_stamp[2*n+1];
        nd_idx[n]   = nd_idx[2*n+1];
        nd_ok[n]    = 1'b1;
      end else begin
        nd_stamp[n] = nd_stamp[2*n+2];
        nd_idx[n]   = nd_idx[2*n+2];
        nd_ok[n]    = nd_ok[2*n+2];
      end
    end
  end

  always_comb begin
    evict = !hit && full;
    priority if (hit) begin
      sel_way = hit_way;
    end else if (full) begin
      sel_way = nd_idx[0];
    end else begin
      sel_way = free_way;
    end
  end

endmodule
`default_nettype wire

// ===== sv/set_assoc_lru_cache_sim_core.sv =====
// Tag store of a set-associative cache with least-recently-used replacement.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 set bits,
// 1 ways in use, 2 block offset bits; cfg_ready is always high, writes are
// meant to land only while no item is in flight.
// Input channel (in_valid/in_ready, in_data): one trace access per item.
// Output channel (out_valid/out_ready, out_data): one result per item with the
// hit, miss, eviction and modify flags and the running totals.
// Each set is one row of a single-port-read memory holding every way's valid
// bit, tag and stamp. An accepted item reads its row on the accept edge, the
// next cycle compares the ways and picks the way, and the row is written back (not
// for a fetch) once the output register is free; only then is a new item taken.
// out_valid rises on the edge that ends ST_LOOK, when the output register is free.
// After reset the block sweeps all 2**MAX_SET_BITS rows to clear them, with
// in_ready low; configuration is taken throughout.
// Results sit in an output register; while it is held by a stalled receiver
// the next item is still accepted and read, but its write-back waits until
// the register frees.
`default_nettype none
module set_assoc_lru_cache_sim_core #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire salc_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output salc_pkg::out_item_t                   out_data
);
  import salc_pkg::*;

  localparam int SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH      = 1 << MAX_SET_BITS;
  localparam int IDX_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W      = MAX_WAYS * (1 + TAG_W + STAMP_W);
  localparam int TAG_BASE   = MAX_WAYS;
  localparam int STAMP_BASE = MAX_WAYS + MAX_WAYS * TAG_W;

  state_t state, state_next;

  logic [2:0]         set_bits;
  logic [3:0]         ways_in_use;
  logic [4:0]         block_bits;

  logic [SET_W-1:0]   clr_idx;
  logic [STAMP_W-1:0] access_stamp;
  logic [CNT_W-1:0]   hit_count;
  logic [CNT_W-1:0]   miss_count;
  logic [CNT_W-1:0]   eviction_count;

  logic [1:0]         op_q;
  logic [TAG_W-1:0]   tag_q;
  logic [SET_W-1:0]   set_q;
  logic [MAX_WAYS-1:0] in_use_q;

  logic [3:0]         eff_sb;
  logic [5:0]         split;
  logic [4:0]         eff_ways;
  logic [TAG_W-1:0]   tag_calc;
  logic [ADDR_W-1:0]  shifted;
  logic [SET_W-1:0]   set_calc;
  logic [MAX_WAYS-1:0] in_use_calc;

  logic               accept;
  logic               look_fire;
  logic               is_fetch;
  logic               mem_wr_en;
  logic [SET_W-1:0]   mem_wr_addr;
  logic [ROW_W-1:0]   mem_wr_data;
  logic [ROW_W-1:0]   rd_row;
  logic [ROW_W-1:0]   new_row;

  logic               sel_hit;
  logic               sel_evict;
  logic [IDX_W-1:0]   sel_way;
  logic               extra;
  logic [CNT_W-1:0]   hit_next;
  logic [CNT_W-1:0]   miss_next;
  logic [CNT_W-1:0]   eviction_next;
  out_item_t          res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_fetch  = (op_q == OP_FETCH);

  // address split with the configured set bits and way count clamped to the built sizes
  always_comb begin
    if (4'(set_bits) > 4'(MAX_SET_BITS)) begin
      eff_sb = 4'(MAX_SET_BITS);
    end else begin
      eff_sb = 4'(set_bits);
    end
    if (ways_in_use == 4'd0) begin
      eff_ways = 5'd1;
    end else if (5'(ways_in_use) > 5'(MAX_WAYS)) begin
      eff_ways = 5'(MAX_WAYS);
    end else begin
      eff_ways = 5'(ways_in_use);
    end
    split    = 6'(block_bits) + 6'(eff_sb);
    tag_calc = (split >= 6'd32) ? '0 : (in_data.address >> split);
    shifted  = in_data.address >> block_bits;
    set_calc = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << eff_sb);
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use_calc[w] = 5'(w) < eff_ways;
    end
  end

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_rows (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (set_calc),
    .rd_data (rd_row)
  );

  salc_way_sel #(
    .MAX_WAYS (MAX_WAYS)
  ) u_way_sel (
    .row     (rd_row),
    .tag     (tag_q),
    .in_use  (in_use_q),
    .hit     (sel_hit),
    .evict   (sel_evict),
    .sel_way (sel_way)
  );

  // the chosen way gets the tag and the current stamp, whether hit or fill
  always_comb begin
    new_row          = rd_row;
    new_row[sel_way] = 1'b1;
    new_row[TAG_BASE + TAG_W*int'(sel_way) +: TAG_W]       = tag_q;
    new_row[STAMP_BASE + STAMP_W*int'(sel_way) +: STAMP_W] = access_stamp;
  end

  always_comb begin
    extra         = !is_fetch && (op_q == OP_MODIFY);
    res.was_hit          = !is_fetch && sel_hit;
    res.was_miss         = !is_fetch && !sel_hit;
    res.was_eviction     = !is_fetch && sel_evict;
    res.modify_extra_hit = extra;
    hit_next      = hit_count + CNT_W'(res.was_hit) + CNT_W'(extra);
    miss_next     = miss_count + CNT_W'(res.was_miss);
    eviction_next = eviction_count + CNT_W'(res.was_eviction);
    res.hit_total      = hit_next;
    res.miss_total     = miss_next;
    res.eviction_total = eviction_next;
  end

  always_comb begin
    state_next  = state;
    look_fire   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = set_q;
    mem_wr_data = new_row;
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_idx;
        mem_wr_data = '0;
        if (clr_idx == SET_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!out_valid || out_ready) begin
          look_fire  = 1'b1;
          mem_wr_en  = !is_fetch;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      out_valid      <= 1'b0;
      access_stamp   <= '0;
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
      set_bits       <= 3'd0;
      ways_in_use    <= 4'd1;
      block_bits     <= 5'd0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + SET_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SET_BITS:   set_bits    <= cfg_data[2:0];
          CFG_WAYS:       ways_in_use <= cfg_data[3:0];
          CFG_BLOCK_BITS: block_bits  <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (look_fire) begin
        out_valid      <= 1'b1;
        hit_count      <= hit_next;
        miss_count     <= miss_next;
        eviction_count <= eviction_next;
        if (!is_fetch) begin
          access_stamp <= access_stamp + STAMP_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= in_data.operation;
      tag_q    <= tag_calc;
      set_q    <= set_calc;
      in_use_q <= in_use_calc;
    end
    if (look_fire) begin
      out_data <= res;
    end
  end

  // a row is never read in the same cycle as a write-back lands
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    accept |-> !mem_wr_en)
    else $error("row read overlaps a write-back");

  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_LOOK)
    else $error("accepted item did not enter lookup");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !out_valid)
    else $error("result shown during clearing sweep");

  a_hit_miss_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.was_hit && out_data.was_miss))
    else $error("item flagged as both hit and miss");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.was_eviction |-> out_data.was_miss)
    else $error("eviction without a miss");

endmodule
`default_nettype wire
